### sv/packed_tile_texel_fetch_defines.svh
// ----------------------------------------------------------------------------
// Packed tile texel fetch assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_TILE_TEXEL_FETCH_DEFINES_SVH
`define PACKED_TILE_TEXEL_FETCH_DEFINES_SVH

`ifndef SYNTHESIS

// Assertion that is switched off while reset is high.
`define PTF_ASSERT_RST(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define PTF_ASSERT_ALL(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define PTF_ASSERT_RST(name, clock, reset, prop, msg)
`define PTF_ASSERT_ALL(name, clock, prop, msg)

`endif

`endif

### sv/ptf_pkg.sv
// ----------------------------------------------------------------------------
// Packed tile texel fetch package
// Shared constants, codes and the 5-bit to 8-bit color expansion table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptf_pkg;

  // Default size of the texture store in bytes.
  localparam int STORE_BYTES_DEF = 262144;

  // Width of the data length register.
  localparam int LEN_W = 19;

  // Width of a computed fetch address before range checks.
  localparam int FETCH_W = 20;

  // Request kinds.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Pixel depth codes.
  localparam logic [1:0] DEPTH_4BPP  = 2'd0;
  localparam logic [1:0] DEPTH_8BPP  = 2'd1;
  localparam logic [1:0] DEPTH_16BPP = 2'd2;
  localparam logic [1:0] DEPTH_NONE  = 2'd3;

  // Rounded expansion of a 5-bit channel to 8 bits, v*255/31.
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

endpackage

`default_nettype wire

### sv/ptf_ram.sv
// ----------------------------------------------------------------------------
// Packed tile texel fetch RAM
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ptf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; the data registers hold while no read is requested.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### sv/packed_tile_texel_fetch.sv
// ----------------------------------------------------------------------------
// Packed tile texel fetch
// Byte-wide texture store with a fetch path for 4-, 8- and 16-bit texels.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                           Direction  Content
//   in       in_valid / in_ready + fields      input      store write or fetch
//   cfg      cfg_valid / cfg_ready, cfg_data   input      data length register
//   out      out_valid / out_ready + fields    output     one pixel per fetch
//
// A request is accepted every cycle unless the output stalls. A fetch reads
// the store into the read-port registers, and its decode then goes into the
// output register. Both bytes of a 16-bit texel come from the two read ports
// of the store in the same cycle. The store has no reset and is undefined
// until written; reset clears only the pipeline valids and the data length.
// A stalled output holds one pixel in the output register and one fetch in
// the read stage before in_ready drops. Writes produce no pixel.
//
`default_nettype none
`include "packed_tile_texel_fetch_defines.svh"

module packed_tile_texel_fetch #(
  parameter int STORE_BYTES = ptf_pkg::STORE_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Request channel.
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     mode,
  input  wire logic [17:0]              write_address,
  input  wire logic [7:0]               write_byte,
  input  wire logic [17:0]              texture_base,
  input  wire logic [1:0]               depth_mode,
  input  wire logic [7:0]               src_x,
  input  wire logic [7:0]               src_y,
  input  wire logic                     tile_size_sel,
  input  wire logic [9:0]               pixel_index,
  // Configuration channel.
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [ptf_pkg::LEN_W-1:0] cfg_data,
  // Result channel.
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          pixel_valid,
  output logic [7:0]                    index_value,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic [7:0]                    alpha
);

  import ptf_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  // Compare width holds a store address plus one and the widest fetch address.
  localparam int CMP_W = (AW + 1 > FETCH_W + 1) ? AW + 1 : FETCH_W + 1;

  // Control state of the read stage.
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [1:0] depth;
    logic       nib_hi;
  } rd_stage_t;

  logic [LEN_W-1:0] data_length;
  rd_stage_t        s1;

  logic             s1_go;
  logic             in_acc;
  logic             fetch_acc;
  logic             store_we;
  logic [CMP_W-1:0] wa_c;
  logic [CMP_W-1:0] store_c;
  logic [CMP_W-1:0] len_c;

  logic [9:0]         idx;
  logic [4:0]         row;
  logic [4:0]         col;
  logic [8:0]         rows;
  logic [8:0]         cols;
  logic [7:0]         half;
  logic [FETCH_W-1:0] row_off;
  logic [FETCH_W-1:0] col_off;
  logic [FETCH_W-1:0] addr;
  logic [CMP_W-1:0]   addr_c;
  logic [CMP_W-1:0]   addr1_c;
  logic               ok0;
  logic               ok1;
  logic               fetch_ok;

  logic [7:0]  byte_lo;
  logic [7:0]  byte_hi;
  logic [15:0] word;
  logic [7:0]  index_next;
  logic [7:0]  red_next;
  logic [7:0]  green_next;
  logic [7:0]  blue_next;
  logic [7:0]  alpha_next;

  // Handshakes. The read stage moves on when the output register is free.
  assign s1_go     = s1.valid && (!out_valid || out_ready);
  assign in_ready  = !s1.valid || s1_go;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign fetch_acc = in_acc && (mode == MODE_FETCH);

  // Writes beyond the store are dropped.
  assign store_c  = CMP_W'(STORE_BYTES);
  assign wa_c     = CMP_W'(write_address);
  assign store_we = in_acc && (mode == MODE_WRITE) && (wa_c < store_c);
  assign len_c    = CMP_W'(data_length);

  // Row and column of the pixel inside its tile.
  always_comb begin
    idx  = tile_size_sel ? pixel_index : {2'b00, pixel_index[7:0]};
    row  = tile_size_sel ? idx[9:5] : {1'b0, idx[7:4]};
    col  = tile_size_sel ? idx[4:0] : {1'b0, idx[3:0]};
    rows = {1'b0, src_y} + {4'b0000, row};
    cols = {1'b0, src_x} + {4'b0000, col};
    half = {1'b0, src_x[7:1]} + {4'b0000, col[4:1]};
  end

  // Byte offsets: the row stride and the pixel size are powers of two.
  always_comb begin
    case (depth_mode)
      DEPTH_4BPP: begin
        row_off = {4'b0, rows, 7'b0};
        col_off = {12'b0, half};
      end
      DEPTH_8BPP: begin
        row_off = {3'b0, rows, 8'b0};
        col_off = {11'b0, cols};
      end
      default: begin
        row_off = {2'b0, rows, 9'b0};
        col_off = {10'b0, cols, 1'b0};
      end
    endcase
  end

  // Address and range checks against the data length and the store size.
  always_comb begin
    addr     = {2'b00, texture_base} + row_off + col_off;
    addr_c   = CMP_W'(addr);
    addr1_c  = addr_c + CMP_W'(1);
    ok0      = (addr_c < len_c) && (addr_c < store_c);
    ok1      = (addr1_c < len_c) && (addr1_c < store_c);
    fetch_ok = (depth_mode != DEPTH_NONE) && ok0 &&
               ((depth_mode != DEPTH_16BPP) || ok1);
  end

  // Texture store. Requests come in order on one channel, so a read never
  // meets a write of the same cycle and needs no forwarding.
  ptf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (wa_c[AW-1:0]),
    .wdata   (write_byte),
    .re      (fetch_acc),
    .raddr_a (addr_c[AW-1:0]),
    .raddr_b (addr1_c[AW-1:0]),
    .rdata_a (byte_lo),
    .rdata_b (byte_hi)
  );

  // Read stage and data length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid    <= 1'b0;
      data_length <= '0;
    end else begin
      if (fetch_acc) begin
        s1.valid <= 1'b1;
      end else if (s1_go) begin
        s1.valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        data_length <= cfg_data;
      end
    end
    if (fetch_acc) begin
      s1.ok     <= fetch_ok;
      s1.depth  <= depth_mode;
      s1.nib_hi <= col[0];
    end
  end

  // Decode of the fetched bytes; an invalid pixel reads as all zero.
  always_comb begin
    word       = {byte_hi, byte_lo};
    index_next = 8'd0;
    red_next   = 8'd0;
    green_next = 8'd0;
    blue_next  = 8'd0;
    alpha_next = 8'd0;
    if (s1.ok) begin
      case (s1.depth)
        DEPTH_4BPP: begin
          index_next = s1.nib_hi ? {4'h0, byte_lo[7:4]} : {4'h0, byte_lo[3:0]};
        end
        DEPTH_8BPP: begin
          index_next = byte_lo;
        end
        default: begin
          red_next   = EXPAND5[word[15:11]];
          green_next = EXPAND5[word[10:6]];
          blue_next  = EXPAND5[word[4:0]];
          alpha_next = (word == 16'h0000) ? 8'd0 : 8'd255;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go) begin
      pixel_valid <= s1.ok;
      index_value <= index_next;
      red         <= red_next;
      green       <= green_next;
      blue        <= blue_next;
      alpha       <= alpha_next;
    end
  end

  // Assertions.
  `PTF_ASSERT_RST(a_fetch_enters_read, clk, rst, fetch_acc |=> s1.valid, "fetch lost before the read stage")
  `PTF_ASSERT_RST(a_read_holds, clk, rst, (s1.valid && !s1_go) |=> s1.valid, "stalled fetch dropped from the read stage")
  `PTF_ASSERT_RST(a_invalid_zero, clk, rst, (out_valid && !pixel_valid) |-> (index_value == 8'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0), "invalid pixel carries nonzero fields")
  `PTF_ASSERT_RST(a_alpha_zero_black, clk, rst, (out_valid && pixel_valid && alpha == 8'd0) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0), "zero alpha with nonzero color")
  `PTF_ASSERT_ALL(a_reset_clears, clk, rst |=> (!out_valid && !s1.valid), "pipeline valid after reset")

endmodule

`default_nettype wire
